// ----- src/cubic_bezier_easing_core_macros.svh -----
// Assertion macros for the cubic-bezier easing core checker.
// No dependencies; included by the checker file.
`ifndef CUBIC_BEZIER_EASING_CORE_MACROS_SVH
`define CUBIC_BEZIER_EASING_CORE_MACROS_SVH

// Implication within the same cycle, disabled while in reset.
`define CBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, disabled while in reset.
`define CBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Implication into the next cycle, checked during reset too.
`define CBE_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cbe_pkg.sv -----
// Shared constants and types for the cubic-bezier easing core.
// No dependencies; used by every module of the block.
package cbe_pkg;

    localparam int ITERATIONS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IO_FRAC        = 16;

    localparam int OUT_MIN = -131072;
    localparam int OUT_MAX = 196608;

    localparam logic [16:0] SECOND_X_RESET = 17'd65536;
    localparam logic [18:0] SECOND_Y_RESET = 19'd65536;

    typedef enum logic [1:0] {
        REG_FIRST_X,
        REG_FIRST_Y,
        REG_SECOND_X,
        REG_SECOND_Y
    } reg_index_t;

endpackage

// ----- src/cbe_newton_step.sv -----
// One pipelined Newton-Raphson step on the x coordinate of the curve.
// Uses cbe_pkg defaults; instantiated in a chain by the top level.
module cbe_newton_step #(
    parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [FRAC_BITS:0]          in_u,
    input  logic [FRAC_BITS:0]          in_t,
    input  logic signed [FRAC_BITS+7:0] x1,
    input  logic signed [FRAC_BITS+7:0] x2,
    output logic                        out_valid,
    output logic [FRAC_BITS:0]          out_u,
    output logic [FRAC_BITS:0]          out_t
);

    localparam int W  = FRAC_BITS + 8;
    localparam int UW = FRAC_BITS + 1;
    localparam int QB = FRAC_BITS + 2;
    localparam int NW = W + FRAC_BITS + 2;
    localparam logic signed [W-1:0] ONE_W = W'(1) <<< FRAC_BITS;
    localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;

    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        logic [2*W-1:0] mag;
        logic [2*W-1:0] half;
        p    = a * b;
        half = (2*W)'(1) << (FRAC_BITS - 1);
        mag  = (p < 0) ? (2*W)'(-p) : (2*W)'(p);
        mag  = (mag + half) >> FRAC_BITS;
        fmul = (p < 0) ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] widen(input logic [UW-1:0] v);
        widen = $signed({{(W-UW){1'b0}}, v});
    endfunction

    // stage 1: powers of u and (1-u)
    logic              v1_reg;
    logic [UW-1:0]     u1_reg, t1_reg;
    logic signed [W-1:0] ww1_reg, wu1_reg, uu1_reg;
    // stage 2: first products against u and the control points
    logic              v2_reg;
    logic [UW-1:0]     u2_reg, t2_reg;
    logic signed [W-1:0] a2_reg, b2_reg, c2_reg, p1_reg, p2_reg, p3_reg;
    // stage 3: curve terms and slope
    logic              v3_reg;
    logic [UW-1:0]     u3_reg, t3_reg;
    logic signed [W-1:0] m1_reg, m2_reg, cu3_reg, d3_reg;
    // divider lanes, index 0 is loaded from stage 3
    logic              dv_reg   [QB+1];
    logic [UW-1:0]     du_reg   [QB+1];
    logic [UW-1:0]     dt_reg   [QB+1];
    logic [NW-1:0]     rem_reg  [QB+1];
    logic [W-1:0]      den_reg  [QB+1];
    logic [QB-1:0]     q_reg    [QB+1];
    logic              neg_reg  [QB+1];
    logic              ovf_reg  [QB+1];
    logic              dz_reg   [QB+1];
    // result
    logic              ov_reg;
    logic [UW-1:0]     ou_reg, ot_reg;

    logic signed [W-1:0] u0w, w0;
    logic signed [W-1:0] u1w, dx, ox;
    logic signed [W-1:0] curve3, err3, slope_next;
    logic [W-1:0]        ae3, ad3;
    logic [UW-1:0]       u_new;
    logic signed [QB+1:0] qs, un;

    always_comb begin
        u0w = widen(in_u);
        w0  = ONE_W - u0w;
        u1w = widen(u1_reg);
        dx  = x2 - x1;
        ox  = ONE_W - x2;
        slope_next = W'(3) * p1_reg + W'(6) * p2_reg + W'(3) * p3_reg;
        curve3 = W'(3) * m1_reg + W'(3) * m2_reg + cu3_reg;
        err3   = curve3 - widen(t3_reg);
        ae3    = (err3 < 0) ? W'(-err3) : W'(err3);
        ad3    = (d3_reg < 0) ? W'(-d3_reg) : W'(d3_reg);
    end

    // apply the correction and keep u on the curve's domain
    always_comb begin
        qs = neg_reg[QB] ? -$signed({2'b00, q_reg[QB]}) : $signed({2'b00, q_reg[QB]});
        un = $signed({{(QB+2-UW){1'b0}}, du_reg[QB]}) - qs;
        priority if (dz_reg[QB]) begin
            u_new = du_reg[QB];
        end else if (ovf_reg[QB]) begin
            u_new = neg_reg[QB] ? ONE_U : '0;
        end else if (un < 0) begin
            u_new = '0;
        end else if (un > $signed({{(QB+2-UW){1'b0}}, ONE_U})) begin
            u_new = ONE_U;
        end else begin
            u_new = un[UW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ov_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg  <= in_u;
            t1_reg  <= in_t;
            ww1_reg <= fmul(w0, w0);
            wu1_reg <= fmul(w0, u0w);
            uu1_reg <= fmul(u0w, u0w);

            u2_reg  <= u1_reg;
            t2_reg  <= t1_reg;
            a2_reg  <= fmul(ww1_reg, u1w);
            b2_reg  <= fmul(wu1_reg, u1w);
            c2_reg  <= fmul(uu1_reg, u1w);
            p1_reg  <= fmul(ww1_reg, x1);
            p2_reg  <= fmul(wu1_reg, dx);
            p3_reg  <= fmul(uu1_reg, ox);

            u3_reg  <= u2_reg;
            t3_reg  <= t2_reg;
            m1_reg  <= fmul(a2_reg, x1);
            m2_reg  <= fmul(b2_reg, x2);
            cu3_reg <= c2_reg;
            d3_reg  <= slope_next;

            du_reg[0]  <= u3_reg;
            dt_reg[0]  <= t3_reg;
            rem_reg[0] <= NW'(ae3) << FRAC_BITS;
            den_reg[0] <= ad3;
            q_reg[0]   <= '0;
            neg_reg[0] <= (err3 < 0) ^ (d3_reg < 0);
            ovf_reg[0] <= {2'b00, ae3} >= {ad3, 2'b00};
            dz_reg[0]  <= (d3_reg == 0);

            ou_reg <= u_new;
            ot_reg <= dt_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v3_reg;
        end
    end

    // restoring division, one quotient bit per stage, most significant first
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [NW-1:0] trial;
        logic          take;
        assign trial = NW'(den_reg[j]) << K;
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                du_reg[j+1]  <= du_reg[j];
                dt_reg[j+1]  <= dt_reg[j];
                den_reg[j+1] <= den_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                dz_reg[j+1]  <= dz_reg[j];
                rem_reg[j+1] <= take ? (rem_reg[j] - trial) : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (take ? (QB'(1) << K) : '0);
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_u     = ou_reg;
    assign out_t     = ot_reg;

endmodule

// ----- src/cbe_y_eval.sv -----
// Pipelined evaluation of the curve's y at the solved parameter, with saturation.
// Uses cbe_pkg for the output range; instantiated once by the top level.
module cbe_y_eval #(
    parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [FRAC_BITS:0]          in_u,
    input  logic signed [FRAC_BITS+7:0] y1,
    input  logic signed [FRAC_BITS+7:0] y2,
    output logic                        out_valid,
    output logic signed [18:0]          out_value
);

    localparam int W  = FRAC_BITS + 8;
    localparam int UW = FRAC_BITS + 1;
    localparam int RW = W + 16;
    localparam int SR = (FRAC_BITS >= cbe_pkg::IO_FRAC) ? FRAC_BITS - cbe_pkg::IO_FRAC : 0;
    localparam int SL = (FRAC_BITS < cbe_pkg::IO_FRAC) ? cbe_pkg::IO_FRAC - FRAC_BITS : 0;
    localparam logic [RW-1:0] HALF = (SR > 0) ? (RW'(1) << (SR > 0 ? SR - 1 : 0)) : '0;
    localparam logic signed [W-1:0] ONE_W = W'(1) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] MIN_R = RW'(cbe_pkg::OUT_MIN);
    localparam logic signed [RW-1:0] MAX_R = RW'(cbe_pkg::OUT_MAX);

    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        logic [2*W-1:0] mag;
        logic [2*W-1:0] half;
        p    = a * b;
        half = (2*W)'(1) << (FRAC_BITS - 1);
        mag  = (p < 0) ? (2*W)'(-p) : (2*W)'(p);
        mag  = (mag + half) >> FRAC_BITS;
        fmul = (p < 0) ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
    endfunction

    logic                v1_reg, v2_reg, v3_reg, ov_reg;
    logic [UW-1:0]       u1_reg;
    logic signed [W-1:0] ww1_reg, wu1_reg, uu1_reg;
    logic signed [W-1:0] a2_reg, b2_reg, c2_reg;
    logic signed [W-1:0] m1_reg, m2_reg, cu3_reg;
    logic signed [18:0]  value_reg;

    logic signed [W-1:0]  u0w, w0, u1w, curve;
    logic signed [RW-1:0] cw, r;
    logic [RW-1:0]        mag;
    logic signed [18:0]   sat;

    always_comb begin
        u0w   = $signed({{(W-UW){1'b0}}, in_u});
        w0    = ONE_W - u0w;
        u1w   = $signed({{(W-UW){1'b0}}, u1_reg});
        curve = W'(3) * m1_reg + W'(3) * m2_reg + cu3_reg;
        cw    = RW'(curve);
        mag   = (cw < 0) ? RW'(-cw) : RW'(cw);
        if (FRAC_BITS >= cbe_pkg::IO_FRAC) begin
            mag = (mag + HALF) >> SR;
            r   = (cw < 0) ? -$signed(mag) : $signed(mag);
        end else begin
            r   = cw <<< SL;
        end
        priority if (r < MIN_R) begin
            sat = 19'(cbe_pkg::OUT_MIN);
        end else if (r > MAX_R) begin
            sat = 19'(cbe_pkg::OUT_MAX);
        end else begin
            sat = r[18:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ov_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg    <= in_u;
            ww1_reg   <= fmul(w0, w0);
            wu1_reg   <= fmul(w0, u0w);
            uu1_reg   <= fmul(u0w, u0w);
            a2_reg    <= fmul(ww1_reg, u1w);
            b2_reg    <= fmul(wu1_reg, u1w);
            c2_reg    <= fmul(uu1_reg, u1w);
            m1_reg    <= fmul(a2_reg, y1);
            m2_reg    <= fmul(b2_reg, y2);
            cu3_reg   <= c2_reg;
            value_reg <= sat;
        end
    end

    assign out_valid = ov_reg;
    assign out_value = value_reg;

endmodule

// ----- src/cubic_bezier_easing_core.sv -----
// Cubic-bezier easing core: top level with stream ports and APB register file.
// Depends on cbe_pkg, cbe_newton_step and cbe_y_eval.
//
// The core maps a progress value t in [0, 1] (17-bit unsigned, 65536 is one)
// onto a cubic-bezier easing curve through (0,0), two programmable control
// points and (1,1). It solves x(u) = t with ITERATIONS Newton-Raphson steps
// starting from u = t, each step laid out as its own pipeline segment, then
// evaluates y(u) and saturates it to [-131072, 196608]. Progress zero yields
// zero and any progress of one or above yields one. The datapath is fully
// pipelined: one transaction is accepted per cycle unless a result is stalled
// on the output, and each Newton step holds a bit-per-stage divider after
// its curve and slope stages. Backpressure on the result channel freezes
// the whole pipeline, the output register serving as the last stage.
// Control points are written through APB at byte addresses 0x0, 0x4, 0x8, 0xC
// and must only be changed while no transaction is in flight.
module cubic_bezier_easing_core #(
    parameter int ITERATIONS = cbe_pkg::ITERATIONS_DEF,
    parameter int FRAC_BITS  = cbe_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] progress, [23:17] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] eased_value, [23:19] zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W  = FRAC_BITS + 8;
    localparam int UW = FRAC_BITS + 1;
    localparam int SL = (FRAC_BITS >= cbe_pkg::IO_FRAC) ? FRAC_BITS - cbe_pkg::IO_FRAC : 0;
    localparam int SR = (FRAC_BITS < cbe_pkg::IO_FRAC) ? cbe_pkg::IO_FRAC - FRAC_BITS : 0;
    localparam logic [19:0] HALF_IN = (SR > 0) ? (20'd1 << (SR > 0 ? SR - 1 : 0)) : 20'd0;
    localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;

    // Convert a 16-fraction-bit value into the working format.
    function automatic logic signed [W-1:0] to_work(input logic signed [19:0] v);
        logic [19:0] mag;
        logic [19:0] rnd;
        mag = (v < 0) ? 20'(-v) : 20'(v);
        rnd = (mag + HALF_IN) >> SR;
        if (FRAC_BITS >= cbe_pkg::IO_FRAC) begin
            to_work = W'(v) <<< SL;
        end else begin
            to_work = (v < 0) ? -$signed(W'(rnd)) : $signed(W'(rnd));
        end
    endfunction

    // control point registers
    logic [16:0] first_x_reg, second_x_reg;
    logic [18:0] first_y_reg, second_y_reg;

    cbe_pkg::reg_index_t wr_index;
    logic                wr_en;

    assign pready   = 1'b1;
    assign wr_index = cbe_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en    = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            second_x_reg <= cbe_pkg::SECOND_X_RESET;
            second_y_reg <= cbe_pkg::SECOND_Y_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                cbe_pkg::REG_FIRST_X:  first_x_reg  <= pwdata[16:0];
                cbe_pkg::REG_FIRST_Y:  first_y_reg  <= pwdata[18:0];
                cbe_pkg::REG_SECOND_X: second_x_reg <= pwdata[16:0];
                cbe_pkg::REG_SECOND_Y: second_y_reg <= pwdata[18:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_index)
            cbe_pkg::REG_FIRST_X:  prdata = {15'd0, first_x_reg};
            cbe_pkg::REG_FIRST_Y:  prdata = {13'd0, first_y_reg};
            cbe_pkg::REG_SECOND_X: prdata = {15'd0, second_x_reg};
            cbe_pkg::REG_SECOND_Y: prdata = {13'd0, second_y_reg};
            default:               prdata = '0;
        endcase
    end

    // Working-format control points; the user must change the registers only while idle, the block does not enforce it.
    logic signed [W-1:0] x1_w, x2_w, y1_w, y2_w;
    assign x1_w = to_work($signed({3'b000, first_x_reg}));
    assign x2_w = to_work($signed({3'b000, second_x_reg}));
    assign y1_w = to_work($signed({first_y_reg[18], first_y_reg}));
    assign y2_w = to_work($signed({second_y_reg[18], second_y_reg}));

    // Advance every stage unless a finished result is held on the output.
    logic en;
    logic y_valid;
    logic signed [18:0] y_value;

    assign en       = !y_valid || m_tready;
    assign s_tready = en;

    // Clamp the progress: zero and one are fixed points of the solver,
    // so both end cases ride the normal datapath and come out exact.
    logic [16:0]    progress;
    logic [UW-1:0]  t_in;
    assign progress = s_tdata[16:0];
    always_comb begin
        if (progress[16]) begin
            t_in = ONE_U;
        end else begin
            t_in = UW'(to_work($signed({3'b000, progress})));
        end
    end

    logic           chain_v [ITERATIONS+1];
    logic [UW-1:0]  chain_u [ITERATIONS+1];
    logic [UW-1:0]  chain_t [ITERATIONS+1];

    assign chain_v[0] = s_tvalid && s_tready;
    assign chain_u[0] = t_in;
    assign chain_t[0] = t_in;

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
        cbe_newton_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_v[i]),
            .in_u      (chain_u[i]),
            .in_t      (chain_t[i]),
            .x1        (x1_w),
            .x2        (x2_w),
            .out_valid (chain_v[i+1]),
            .out_u     (chain_u[i+1]),
            .out_t     (chain_t[i+1])
        );
    end

    cbe_y_eval #(
        .FRAC_BITS (FRAC_BITS)
    ) u_y_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_v[ITERATIONS]),
        .in_u      (chain_u[ITERATIONS]),
        .y1        (y1_w),
        .y2        (y2_w),
        .out_valid (y_valid),
        .out_value (y_value)
    );

    // The target leaving the last step is not needed past the solver;
    // reduce it into the zero pad so it stays consumed.
    logic unused_t;
    assign unused_t = ^chain_t[ITERATIONS];

    assign m_tvalid = y_valid;
    assign m_tdata  = {5'd0 & {5{unused_t}}, y_value};

endmodule

// ----- src/cbe_checker.sv -----
// Port-level checker for the cubic-bezier easing core, bound to the top level.
// Depends on cubic_bezier_easing_core_macros.svh.
`include "cubic_bezier_easing_core_macros.svh"

module cbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // reset empties the pipeline
    `CBE_ASSERT_RESET(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

    // a held result keeps its value
    `CBE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // an empty output never blocks the input
    `CBE_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // the input stalls only while the output is stalled
    `CBE_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled without cause")

    // pad bits stay zero and the result is never the most negative 19-bit code
    `CBE_ASSERT_SAME(a_range, m_tvalid, (m_tdata[23:19] == 5'd0) && (m_tdata[18:0] != 19'h40000), "result out of range")

endmodule

bind cubic_bezier_easing_core cbe_checker u_cbe_checker (.*);
